FILE: rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg: shared widths, constants and types of the circumcircle unit
// Widths follow from the 32-bit signed coordinate fields.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int CW        = 32;   // coordinate width
  localparam int DW        = 33;   // coordinate difference
  localparam int PW        = 66;   // product of two differences
  localparam int DETW      = 67;   // determinant
  localparam int SW        = 66;   // sum of squares
  localparam int HW        = 33;   // half of a sum of squares
  localparam int PPW       = 67;   // partial product
  localparam int DENW      = 68;   // twice the determinant
  localparam int NW        = 100;  // numerator and divider remainder
  localparam int QW        = 32;   // quotient bits
  localparam int SQW       = 66;   // radicand
  localparam int RTW       = 67;   // square root working value
  localparam int RBITS     = 33;   // root bits
  localparam int DIV_CELLS = QW;
  localparam int SQ_CELLS  = RBITS;

  localparam logic [CW-1:0]  TOL_RESET = 32'd4295;
  localparam logic [CW-1:0]  POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [CW-1:0]  NEG_MAX   = 32'h8000_0000;
  localparam logic [CW-1:0]  RAD_MAX   = 32'hFFFF_FFFF;
  localparam logic [SQW-1:0] ONE_INIT  = {2'b01, 64'b0};

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] z1;
    logic                 found;
    logic                 neg_x;
    logic                 neg_y;
    logic                 big_x;
    logic                 big_y;
  } div_side_t;

  typedef struct packed {
    logic          found;
    logic          ovf;
    logic          rsat;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] z;
  } sqrt_side_t;

endpackage

FILE: rtl/cfp_div_cell.sv
// ----------------------------------------------------------------------------
// cfp_div_cell: one restoring division step for the x and y lanes
// Produces one quotient bit per lane and passes the request on.
// ----------------------------------------------------------------------------
module cfp_div_cell import cfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [1:0][NW-1:0]    in_rem,
  input  logic [1:0][NW-1:0]    in_dsh,
  input  logic [1:0][QW-1:0]    in_q,
  input  div_side_t             in_side,
  output logic                  out_vld,
  output logic [1:0][NW-1:0]    out_rem,
  output logic [1:0][NW-1:0]    out_dsh,
  output logic [1:0][QW-1:0]    out_q,
  output div_side_t             out_side
);

  logic                 vld_r;
  logic [1:0][NW-1:0]   rem_r, rem_nxt;
  logic [1:0][NW-1:0]   dsh_r, dsh_nxt;
  logic [1:0][QW-1:0]   q_r, q_nxt;
  div_side_t            side_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (in_rem[l] >= in_dsh[l]) begin
        rem_nxt[l] = in_rem[l] - in_dsh[l];
        q_nxt[l]   = {in_q[l][QW-2:0], 1'b1};
      end else begin
        rem_nxt[l] = in_rem[l];
        q_nxt[l]   = {in_q[l][QW-2:0], 1'b0};
      end
      dsh_nxt[l] = in_dsh[l] >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_dsh  = dsh_r;
  assign out_q    = q_r;
  assign out_side = side_r;

endmodule

FILE: rtl/cfp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cfp_sqrt_cell: one digit-by-digit integer square root step
// Decides one root bit and passes the request on.
// ----------------------------------------------------------------------------
module cfp_sqrt_cell import cfp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [SQW-1:0]   in_op,
  input  logic [RTW-1:0]   in_res,
  input  logic [SQW-1:0]   in_one,
  input  sqrt_side_t       in_side,
  output logic             out_vld,
  output logic [SQW-1:0]   out_op,
  output logic [RTW-1:0]   out_res,
  output logic [SQW-1:0]   out_one,
  output sqrt_side_t       out_side
);

  logic             vld_r;
  logic [SQW-1:0]   op_r, op_nxt;
  logic [RTW-1:0]   res_r, res_nxt;
  logic [SQW-1:0]   one_r;
  sqrt_side_t       side_r;
  logic [RTW-1:0]   trial;

  always_comb begin
    trial = in_res + RTW'(in_one);
    if (RTW'(in_op) >= trial) begin
      op_nxt  = in_op - trial[SQW-1:0];
      res_nxt = (in_res >> 1) + RTW'(in_one);
    end else begin
      op_nxt  = in_op;
      res_nxt = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    op_r   <= op_nxt;
    res_r  <= res_nxt;
    one_r  <= in_one >> 2;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_op   = op_r;
  assign out_res  = res_r;
  assign out_one  = one_r;
  assign out_side = side_r;

endmodule

FILE: rtl/circle_from_three_points_unit.sv
// ----------------------------------------------------------------------------
// circle_from_three_points_unit: circumcircle of three points in Q16.16
// A request passes stages A to G, the divider cells, stages H and I, the square root cells and an output register.
// One request is accepted every cycle; busy stays low and results cannot stall.
// The pipeline holds 32 divider cells and 33 square root cells in series.
// Synchronous reset empties the pipeline and loads the default tolerance.
// ----------------------------------------------------------------------------
module circle_from_three_points_unit import cfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_first_x,
  input  logic signed [CW-1:0] in_first_y,
  input  logic signed [CW-1:0] in_first_z,
  input  logic signed [CW-1:0] in_second_x,
  input  logic signed [CW-1:0] in_second_y,
  input  logic signed [CW-1:0] in_third_x,
  input  logic signed [CW-1:0] in_third_y,
  input  logic                 cfg_we,
  input  logic [CW-1:0]        cfg_wdata,
  output logic                 out_valid,
  output logic                 out_found,
  output logic signed [CW-1:0] out_center_x,
  output logic signed [CW-1:0] out_center_y,
  output logic signed [CW-1:0] out_center_z,
  output logic [CW-1:0]        out_radius,
  output logic                 out_overflow
);

  function automatic logic [CW:0] sat_center(input logic signed [CW+2:0] sum,
                                             input logic big, input logic neg);
    logic [CW:0] r;
    if (big) begin
      r = neg ? {1'b1, NEG_MAX} : {1'b1, POS_MAX};
    end else if (sum[CW+2:CW-1] == 4'b0000 || sum[CW+2:CW-1] == 4'b1111) begin
      r = {1'b0, sum[CW-1:0]};
    end else begin
      r = sum[CW+2] ? {1'b1, NEG_MAX} : {1'b1, POS_MAX};
    end
    return r;
  endfunction

  logic            in_acc;
  logic [CW-1:0]   tol_r;
  logic [6:0]      front_vld_r;

  // Stage A: differences.
  logic signed [DW-1:0] a_u2_r, a_v2_r, a_u3_r, a_v3_r;
  logic signed [CW-1:0] a_x1_r, a_y1_r, a_z1_r;
  // Stage B: products.
  logic signed [PW-1:0] b_uv_r, b_vu_r, b_uu2_r, b_vv2_r, b_uu3_r, b_vv3_r;
  logic signed [DW-1:0] b_u2_r, b_v2_r, b_u3_r, b_v3_r;
  logic signed [CW-1:0] b_x1_r, b_y1_r, b_z1_r;
  // Stage C: determinant and sums of squares.
  logic signed [DETW-1:0] c_d_nxt, c_d_r;
  logic [DETW-1:0]        c_absd;
  logic [SW-1:0]          c_s2_r, c_s3_r;
  logic signed [DW-1:0]   c_u2_r, c_v2_r, c_u3_r, c_v3_r;
  logic signed [CW-1:0]   c_x1_r, c_y1_r, c_z1_r;
  logic                   c_found_r;
  // Stage D: partial products.
  logic signed [HW:0]     s2_lo, s2_hi, s3_lo, s3_hi;
  logic signed [PPW-1:0]  d_alo_r, d_ahi_r, d_blo_r, d_bhi_r;
  logic signed [PPW-1:0]  d_clo_r, d_chi_r, d_elo_r, d_ehi_r;
  logic signed [DENW-1:0] d_den_r;
  logic signed [CW-1:0]   d_x1_r, d_y1_r, d_z1_r;
  logic                   d_found_r;
  // Stage E: numerators.
  logic signed [NW-1:0]   e_numx_r, e_numy_r;
  logic signed [DENW-1:0] e_den_r;
  logic signed [CW-1:0]   e_x1_r, e_y1_r, e_z1_r;
  logic                   e_found_r;
  // Stage F: magnitudes.
  logic [NW-1:0]          f_absx_r, f_absy_r;
  logic [DENW-1:0]        f_absd_r;
  logic                   f_negx_r, f_negy_r;
  logic signed [CW-1:0]   f_x1_r, f_y1_r, f_z1_r;
  logic                   f_found_r;
  // Stage G: divider setup.
  logic [1:0][NW-1:0]     g_rem_r, g_dsh_r;
  div_side_t              g_side_r;

  logic                   dv_vld  [DIV_CELLS+1];
  logic [1:0][NW-1:0]     dv_rem  [DIV_CELLS+1];
  logic [1:0][NW-1:0]     dv_dsh  [DIV_CELLS+1];
  logic [1:0][QW-1:0]     dv_q    [DIV_CELLS+1];
  div_side_t              dv_side [DIV_CELLS+1];

  // Stage H: centre and squared offsets.
  div_side_t              hs;
  logic signed [QW+1:0]   ox, oy;
  logic [CW:0]            satx, saty;
  logic                   h_vld_r;
  logic [2*QW-1:0]        h_sqx_r, h_sqy_r;
  sqrt_side_t             h_side_r;
  // Stage I: radicand.
  logic                   i_vld_r;
  logic [SQW-1:0]         i_sq_r;
  sqrt_side_t             i_side_r;

  logic                   sq_vld  [SQ_CELLS+1];
  logic [SQW-1:0]         sq_op   [SQ_CELLS+1];
  logic [RTW-1:0]         sq_res  [SQ_CELLS+1];
  logic [SQW-1:0]         sq_one  [SQ_CELLS+1];
  sqrt_side_t             sq_side [SQ_CELLS+1];

  sqrt_side_t             os;
  logic [RTW-1:0]         root;
  logic                   rad_sat;
  logic                   o_vld_r, o_found_r, o_ovf_r;
  logic [CW-1:0]          o_cx_r, o_cy_r, o_z_r, o_rad_r;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= TOL_RESET;
      front_vld_r <= '0;
      h_vld_r     <= 1'b0;
      i_vld_r     <= 1'b0;
      o_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      front_vld_r <= {front_vld_r[5:0], in_acc};
      h_vld_r     <= dv_vld[DIV_CELLS];
      i_vld_r     <= h_vld_r;
      o_vld_r     <= sq_vld[SQ_CELLS];
    end
  end

  always_comb begin
    c_d_nxt = DETW'(b_uv_r) - DETW'(b_vu_r);
    c_absd  = c_d_nxt[DETW-1] ? DETW'(-c_d_nxt) : DETW'(c_d_nxt);
    s2_lo   = $signed({1'b0, c_s2_r[HW-1:0]});
    s2_hi   = $signed({1'b0, c_s2_r[SW-1:HW]});
    s3_lo   = $signed({1'b0, c_s3_r[HW-1:0]});
    s3_hi   = $signed({1'b0, c_s3_r[SW-1:HW]});
  end

  always_ff @(posedge clk) begin
    a_u2_r <= DW'(in_second_x) - DW'(in_first_x);
    a_v2_r <= DW'(in_second_y) - DW'(in_first_y);
    a_u3_r <= DW'(in_third_x) - DW'(in_first_x);
    a_v3_r <= DW'(in_third_y) - DW'(in_first_y);
    a_x1_r <= in_first_x;
    a_y1_r <= in_first_y;
    a_z1_r <= in_first_z;

    b_uv_r  <= PW'(a_u2_r) * PW'(a_v3_r);
    b_vu_r  <= PW'(a_u3_r) * PW'(a_v2_r);
    b_uu2_r <= PW'(a_u2_r) * PW'(a_u2_r);
    b_vv2_r <= PW'(a_v2_r) * PW'(a_v2_r);
    b_uu3_r <= PW'(a_u3_r) * PW'(a_u3_r);
    b_vv3_r <= PW'(a_v3_r) * PW'(a_v3_r);
    b_u2_r  <= a_u2_r;
    b_v2_r  <= a_v2_r;
    b_u3_r  <= a_u3_r;
    b_v3_r  <= a_v3_r;
    b_x1_r  <= a_x1_r;
    b_y1_r  <= a_y1_r;
    b_z1_r  <= a_z1_r;

    c_d_r     <= c_d_nxt;
    c_s2_r    <= $unsigned(b_uu2_r) + $unsigned(b_vv2_r);
    c_s3_r    <= $unsigned(b_uu3_r) + $unsigned(b_vv3_r);
    c_found_r <= !((c_d_nxt == '0) || (c_absd < DETW'(tol_r)));
    c_u2_r    <= b_u2_r;
    c_v2_r    <= b_v2_r;
    c_u3_r    <= b_u3_r;
    c_v3_r    <= b_v3_r;
    c_x1_r    <= b_x1_r;
    c_y1_r    <= b_y1_r;
    c_z1_r    <= b_z1_r;

    d_alo_r   <= PPW'(c_v3_r) * PPW'(s2_lo);
    d_ahi_r   <= PPW'(c_v3_r) * PPW'(s2_hi);
    d_blo_r   <= PPW'(c_v2_r) * PPW'(s3_lo);
    d_bhi_r   <= PPW'(c_v2_r) * PPW'(s3_hi);
    d_clo_r   <= PPW'(c_u2_r) * PPW'(s3_lo);
    d_chi_r   <= PPW'(c_u2_r) * PPW'(s3_hi);
    d_elo_r   <= PPW'(c_u3_r) * PPW'(s2_lo);
    d_ehi_r   <= PPW'(c_u3_r) * PPW'(s2_hi);
    d_den_r   <= DENW'(c_d_r) <<< 1;
    d_x1_r    <= c_x1_r;
    d_y1_r    <= c_y1_r;
    d_z1_r    <= c_z1_r;
    d_found_r <= c_found_r;

    e_numx_r  <= (NW'(d_ahi_r) <<< HW) + NW'(d_alo_r)
               - (NW'(d_bhi_r) <<< HW) - NW'(d_blo_r);
    e_numy_r  <= (NW'(d_chi_r) <<< HW) + NW'(d_clo_r)
               - (NW'(d_ehi_r) <<< HW) - NW'(d_elo_r);
    e_den_r   <= d_den_r;
    e_x1_r    <= d_x1_r;
    e_y1_r    <= d_y1_r;
    e_z1_r    <= d_z1_r;
    e_found_r <= d_found_r;

    f_absx_r  <= e_numx_r[NW-1] ? NW'(-e_numx_r) : NW'(e_numx_r);
    f_absy_r  <= e_numy_r[NW-1] ? NW'(-e_numy_r) : NW'(e_numy_r);
    f_absd_r  <= e_den_r[DENW-1] ? DENW'(-e_den_r) : DENW'(e_den_r);
    f_negx_r  <= e_numx_r[NW-1] ^ e_den_r[DENW-1];
    f_negy_r  <= e_numy_r[NW-1] ^ e_den_r[DENW-1];
    f_x1_r    <= e_x1_r;
    f_y1_r    <= e_y1_r;
    f_z1_r    <= e_z1_r;
    f_found_r <= e_found_r;

    g_rem_r[0]     <= f_absx_r;
    g_rem_r[1]     <= f_absy_r;
    g_dsh_r[0]     <= NW'({f_absd_r, {(QW-1){1'b0}}});
    g_dsh_r[1]     <= NW'({f_absd_r, {(QW-1){1'b0}}});
    g_side_r.x1    <= f_x1_r;
    g_side_r.y1    <= f_y1_r;
    g_side_r.z1    <= f_z1_r;
    g_side_r.found <= f_found_r;
    g_side_r.neg_x <= f_negx_r;
    g_side_r.neg_y <= f_negy_r;
    g_side_r.big_x <= f_absx_r >= {f_absd_r, {QW{1'b0}}};
    g_side_r.big_y <= f_absy_r >= {f_absd_r, {QW{1'b0}}};
  end

  assign dv_vld[0]  = front_vld_r[6];
  assign dv_rem[0]  = g_rem_r;
  assign dv_dsh[0]  = g_dsh_r;
  assign dv_q[0]    = '0;
  assign dv_side[0] = g_side_r;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    cfp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[k]),
      .in_rem   (dv_rem[k]),
      .in_dsh   (dv_dsh[k]),
      .in_q     (dv_q[k]),
      .in_side  (dv_side[k]),
      .out_vld  (dv_vld[k+1]),
      .out_rem  (dv_rem[k+1]),
      .out_dsh  (dv_dsh[k+1]),
      .out_q    (dv_q[k+1]),
      .out_side (dv_side[k+1])
    );
  end

  always_comb begin
    hs   = dv_side[DIV_CELLS];
    ox   = hs.neg_x ? -$signed({2'b00, dv_q[DIV_CELLS][0]})
                    : $signed({2'b00, dv_q[DIV_CELLS][0]});
    oy   = hs.neg_y ? -$signed({2'b00, dv_q[DIV_CELLS][1]})
                    : $signed({2'b00, dv_q[DIV_CELLS][1]});
    satx = sat_center((CW+3)'(hs.x1) + (CW+3)'(ox), hs.big_x, hs.neg_x);
    saty = sat_center((CW+3)'(hs.y1) + (CW+3)'(oy), hs.big_y, hs.neg_y);
  end

  always_ff @(posedge clk) begin
    h_sqx_r        <= (2*QW)'(dv_q[DIV_CELLS][0]) * (2*QW)'(dv_q[DIV_CELLS][0]);
    h_sqy_r        <= (2*QW)'(dv_q[DIV_CELLS][1]) * (2*QW)'(dv_q[DIV_CELLS][1]);
    h_side_r.found <= hs.found;
    h_side_r.rsat  <= hs.big_x || hs.big_y;
    h_side_r.ovf   <= satx[CW] || saty[CW] || hs.big_x || hs.big_y;
    h_side_r.cx    <= satx[CW-1:0];
    h_side_r.cy    <= saty[CW-1:0];
    h_side_r.z     <= hs.z1;
    i_sq_r         <= SQW'(h_sqx_r) + SQW'(h_sqy_r);
    i_side_r       <= h_side_r;
  end

  assign sq_vld[0]  = i_vld_r;
  assign sq_op[0]   = i_sq_r;
  assign sq_res[0]  = '0;
  assign sq_one[0]  = ONE_INIT;
  assign sq_side[0] = i_side_r;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    cfp_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[k]),
      .in_op    (sq_op[k]),
      .in_res   (sq_res[k]),
      .in_one   (sq_one[k]),
      .in_side  (sq_side[k]),
      .out_vld  (sq_vld[k+1]),
      .out_op   (sq_op[k+1]),
      .out_res  (sq_res[k+1]),
      .out_one  (sq_one[k+1]),
      .out_side (sq_side[k+1])
    );
  end

  always_comb begin
    os      = sq_side[SQ_CELLS];
    root    = sq_res[SQ_CELLS];
    rad_sat = os.rsat || root[RBITS-1];
  end

  always_ff @(posedge clk) begin
    o_found_r <= os.found;
    o_cx_r    <= os.found ? os.cx : '0;
    o_cy_r    <= os.found ? os.cy : '0;
    o_z_r     <= os.found ? os.z : '0;
    o_rad_r   <= !os.found ? '0 : (rad_sat ? RAD_MAX : root[CW-1:0]);
    o_ovf_r   <= os.found && (os.ovf || rad_sat);
  end

  assign out_valid    = o_vld_r;
  assign out_found    = o_found_r;
  assign out_center_x = o_cx_r;
  assign out_center_y = o_cy_r;
  assign out_center_z = o_z_r;
  assign out_radius   = o_rad_r;
  assign out_overflow = o_ovf_r;

  // A collinear result carries nothing but zeros.
  a_collinear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_center_x == '0 && out_center_y == '0 &&
      out_center_z == '0 && out_radius == '0 && !out_overflow)
    else $error("collinear result not cleared");

  // Every result comes from an accepted request.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 75))
    else $error("result without matching request");

  // Overflow implies that at least one output sits at a saturation bound.
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_center_x == POS_MAX ||
      out_center_x == NEG_MAX || out_center_y == POS_MAX ||
      out_center_y == NEG_MAX || out_radius == RAD_MAX)
    else $error("overflow without saturated output");

endmodule
